// File: rtl/brrte_pkg.sv
// ============================================================================
// brrte_pkg
// Types, register indexes and size limits shared by the run-table encoder.
// ============================================================================
package brrte_pkg;

    localparam int PIX_W    = 8;
    localparam int COL_W    = 12;
    localparam int LEN_W    = 13;
    localparam int CNT_W    = 25;
    localparam int CFG_DW   = 13;
    localparam int CFG_AW   = 2;

    localparam logic [LEN_W-1:0] MAX_WIDTH     = 13'd4096;
    localparam logic [LEN_W-1:0] MAX_HEIGHT    = 13'd4096;
    localparam logic [CNT_W-1:0] WORDS_PER_RUN = 25'd2;

    // result queue depth: room for the two records one pixel may cause, plus slack
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        MODE_NONZERO  = 2'd0,
        MODE_ZERO     = 2'd1,
        MODE_MASK_IMG = 2'd2,
        MODE_MASK_BIT = 2'd3
    } mode_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_MODE         = 2'd0,
        REG_ROW_WIDTH    = 2'd1,
        REG_FRAME_HEIGHT = 2'd2,
        REG_MASK_BITS    = 2'd3
    } reg_idx_t;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_ROW = 1'b1;

    typedef struct packed {
        logic             record_kind;
        logic [COL_W-1:0] run_start;
        logic [LEN_W-1:0] run_length;
        logic [COL_W-1:0] row_index;
        logic [CNT_W-1:0] row_offset;
        logic [CNT_W-1:0] pixel_total;
        logic             frame_done;
        logic             last;
    } rec_t;

endpackage

// File: rtl/brrte_if.sv
// ============================================================================
// brrte_if
// Valid/ready channels of the run-table encoder: pixels, records, config.
// ============================================================================
interface brrte_pix_if import brrte_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] mask_pixel;

    modport source (output valid, output pixel, output mask_pixel, input ready);
    modport sink   (input valid, input pixel, input mask_pixel, output ready);
endinterface

interface brrte_rec_if import brrte_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             record_kind;
    logic [COL_W-1:0] run_start;
    logic [LEN_W-1:0] run_length;
    logic [COL_W-1:0] row_index;
    logic [CNT_W-1:0] row_offset;
    logic [CNT_W-1:0] pixel_total;
    logic             frame_done;
    logic             last;

    modport source (output valid, output record_kind, output run_start,
                    output run_length, output row_index, output row_offset,
                    output pixel_total, output frame_done, output last,
                    input ready);
    modport sink   (input valid, input record_kind, input run_start,
                    input run_length, input row_index, input row_offset,
                    input pixel_total, input frame_done, input last,
                    output ready);
endinterface

interface brrte_cfg_if import brrte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/binary_row_run_table_encoder.sv
// ============================================================================
// binary_row_run_table_encoder
// Classifies raster pixels as foreground and emits run and row records.
// ============================================================================
// Usage:
//   pixels  - one request per raster pixel (pixel, mask_pixel).
//   records - run records (start, length, table offset) and one row record
//             after the last pixel of each row; last marks the final record
//             a pixel caused. A pixel causes zero, one or two records.
//   cfg     - register writes (mode, row_width, frame_height, mask_bits),
//             always ready; write only while no pixel is in flight.
// Records: a record enters the queue as its pixel is accepted and shows
//   on records once those ahead of it drain. Throughput: one pixel per
//   cycle while the receiver keeps up; classification is combinational,
//   counters register on accept, and the queue drains one record per cycle.
// Stall: records wait in a four-entry queue; pixels are accepted while at
//   least two entries are free, so the queue never overflows.
// Reset: counters, queue and position clear; registers return to mode 0,
//   4096 x 4096 frame, mask_bits 255.
// ============================================================================
module binary_row_run_table_encoder import brrte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    brrte_pix_if.sink   pixels,
    brrte_rec_if.source records,
    brrte_cfg_if.sink   cfg
);

    mode_t             mode_reg;
    logic [LEN_W-1:0]  row_width_reg;
    logic [LEN_W-1:0]  frame_height_reg;
    logic [PIX_W-1:0]  mask_bits_reg;

    logic [COL_W-1:0]  column_reg,    column_next;
    logic [COL_W-1:0]  row_reg,       row_next;
    logic [LEN_W-1:0]  run_len_reg,   run_len_next;
    logic [COL_W-1:0]  run_start_reg, run_start_next;
    logic [CNT_W-1:0]  words_reg,     words_next;
    logic [CNT_W-1:0]  total_reg,     total_next;

    rec_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg,  count_next;

    logic              accept;
    logic              pop;
    logic              fg;
    logic [LEN_W-1:0]  width_eff;
    logic [LEN_W-1:0]  height_eff;
    logic              close_bg;
    logic              close_end;
    logic              run_valid;
    logic              row_end;
    logic              frame_end;
    logic [LEN_W-1:0]  len_after;
    logic [COL_W-1:0]  start_after;
    logic [CNT_W-1:0]  total_after;
    logic [CNT_W-1:0]  words_after;
    logic [1:0]        push_n;
    rec_t              run_rec;
    rec_t              row_rec;
    rec_t              first_rec;
    rec_t              head_rec;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NONZERO;
            row_width_reg    <= MAX_WIDTH;
            frame_height_reg <= MAX_HEIGHT;
            mask_bits_reg    <= '1;
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_MODE:         mode_reg         <= mode_t'(cfg.data[1:0]);
                REG_ROW_WIDTH:    row_width_reg    <= cfg.data[LEN_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data[LEN_W-1:0];
                REG_MASK_BITS:    mask_bits_reg    <= cfg.data[PIX_W-1:0];
                default:          mode_reg         <= mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // per-pixel classification and record formation
    // ------------------------------------------------------------------------
    assign accept = pixels.valid && pixels.ready;
    assign pop    = records.valid && records.ready;

    always_comb
    begin
        // zero means one, anything above the limit saturates
        if (row_width_reg == '0)
            width_eff = LEN_W'(1);
        else if (row_width_reg > MAX_WIDTH)
            width_eff = MAX_WIDTH;
        else
            width_eff = row_width_reg;

        if (frame_height_reg == '0)
            height_eff = LEN_W'(1);
        else if (frame_height_reg > MAX_HEIGHT)
            height_eff = MAX_HEIGHT;
        else
            height_eff = frame_height_reg;

        case (mode_reg)
            MODE_NONZERO:  fg = (pixels.pixel != '0);
            MODE_ZERO:     fg = (pixels.pixel == '0);
            MODE_MASK_IMG: fg = (pixels.pixel != '0) && (pixels.mask_pixel != '0);
            MODE_MASK_BIT: fg = ((pixels.pixel & mask_bits_reg) != '0);
            default:       fg = 1'b0;
        endcase
    end

    always_comb
    begin
        total_after = fg ? total_reg + CNT_W'(1) : total_reg;
        close_bg    = !fg && (run_len_reg != '0);
        start_after = (fg && (run_len_reg == '0)) ? column_reg : run_start_reg;

        if (fg)
            len_after = run_len_reg + LEN_W'(1);
        else if (close_bg)
            len_after = '0;
        else
            len_after = run_len_reg;

        row_end   = ({1'b0, column_reg} + LEN_W'(1)) >= width_eff;
        frame_end = ({1'b0, row_reg} + LEN_W'(1)) >= height_eff;
        close_end = row_end && (len_after != '0);
        run_valid = close_bg || close_end;

        words_after = run_valid ? words_reg + WORDS_PER_RUN : words_reg;

        // a closing background pixel and a row-end close never both happen
        run_rec.record_kind = KIND_RUN;
        run_rec.run_start   = start_after;
        run_rec.run_length  = close_bg ? run_len_reg : len_after;
        run_rec.row_index   = row_reg;
        run_rec.row_offset  = words_reg;
        run_rec.pixel_total = total_after;
        run_rec.frame_done  = 1'b0;
        run_rec.last        = !row_end;

        row_rec.record_kind = KIND_ROW;
        row_rec.run_start   = '0;
        row_rec.run_length  = '0;
        row_rec.row_index   = row_reg;
        row_rec.row_offset  = words_after;
        row_rec.pixel_total = total_after;
        row_rec.frame_done  = frame_end;
        row_rec.last        = 1'b1;

        first_rec = run_valid ? run_rec : row_rec;
        push_n    = {1'b0, run_valid} + {1'b0, row_end};

        // state after this pixel
        run_len_next   = run_valid ? '0 : len_after;
        run_start_next = start_after;
        if (row_end)
        begin
            column_next = '0;
            row_next    = frame_end ? '0 : row_reg + COL_W'(1);
            words_next  = frame_end ? '0 : words_after;
            total_next  = frame_end ? '0 : total_after;
        end
        else
        begin
            column_next = column_reg + COL_W'(1);
            row_next    = row_reg;
            words_next  = words_after;
            total_next  = total_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            run_len_reg   <= '0;
            run_start_reg <= '0;
            words_reg     <= '0;
            total_reg     <= '0;
        end
        else if (accept)
        begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            run_len_reg   <= run_len_next;
            run_start_reg <= run_start_next;
            words_reg     <= words_next;
            total_reg     <= total_next;
        end
    end

    // ------------------------------------------------------------------------
    // record queue
    // ------------------------------------------------------------------------
    // hold off new pixels unless both records of a worst-case pixel fit
    assign pixels.ready = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + FIFO_AW'(push_n) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg
                    + (accept ? (FIFO_AW+1)'(push_n) : '0)
                    - (pop ? (FIFO_AW+1)'(1) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (push_n != 2'd0)
                fifo_mem[wr_ptr_reg] <= first_rec;
            if (push_n == 2'd2)
                fifo_mem[wr_ptr_reg + FIFO_AW'(1)] <= row_rec;
        end
    end

    assign head_rec = fifo_mem[rd_ptr_reg];

    assign records.valid       = (count_reg != '0);
    assign records.record_kind = head_rec.record_kind;
    assign records.run_start   = head_rec.run_start;
    assign records.run_length  = head_rec.run_length;
    assign records.row_index   = head_rec.row_index;
    assign records.row_offset  = head_rec.row_offset;
    assign records.pixel_total = head_rec.pixel_total;
    assign records.frame_done  = head_rec.frame_done;
    assign records.last        = head_rec.last;

endmodule
